[rtl/core/sdg_pkg.sv]
package sdg_pkg;

  localparam int unsigned COORD_W  = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  typedef logic [COORD_W-1:0] coord_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STILL_THR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_CNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_CD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_CD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_RATE   = 3'd5;

  // reset values of the configuration registers
  localparam coord_t     RST_SWIPE_THR   = 9'd50;
  localparam coord_t     RST_STILL_THR   = 9'd15;
  localparam logic [3:0] RST_CONFIRM_CNT = 4'd5;
  localparam logic [7:0] RST_SWIPE_CD    = 8'd30;
  localparam logic [7:0] RST_PAUSE_CD    = 8'd45;
  localparam logic [3:0] RST_SKIP_RATE   = 4'd2;

  // still counter saturates here
  localparam logic [3:0] STILL_MAX = 4'd15;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_FWD   = 2'd1,
    EV_BACK  = 2'd2,
    EV_PAUSE = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    DET_NONE  = 2'd0,
    DET_FWD   = 2'd1,
    DET_BACK  = 2'd2,
    DET_STILL = 2'd3
  } det_t;

  typedef struct packed {
    logic   hand_present;
    coord_t hand_x;
    coord_t hand_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic       paused;
    logic       analysed;
  } out_item_t;

  typedef struct packed {
    coord_t     swipe_dist;
    coord_t     still_threshold;
    logic [3:0] confirm_count;
    logic [7:0] swipe_cooldown;
    logic [7:0] pause_cooldown;
    logic [3:0] skip_rate;
  } cfg_t;

endpackage

[rtl/core/swipe_and_dwell_gesture_detector.sv]
// Swipe and dwell gesture detector. Each input transaction is one camera
// frame (hand-present flag and hand centroid); each frame yields exactly one
// output transaction with the event code (none, swipe forward, swipe back,
// pause toggled), the paused flag after the frame, and whether the frame was
// analysed. Only one frame in every skip_rate+1 is analysed. Throughput is
// one transaction per clock while out_stall is low: the whole per-frame state
// update is combinational logic in the evaluation stage, between the input
// register and the output register. A frame accepted into the input register
// is loaded into the output register once that register is empty or being
// drained; out_valid then rises and the result can be taken.
// in_stall rises only while both the input register and the output register
// hold a transaction and out_stall is high. Configuration is written through
// cfg_we/cfg_index/cfg_wdata with the block idle; unused indexes are ignored.
module swipe_and_dwell_gesture_detector (
  input  logic                             clk,
  input  logic                             rst_n,
  // frame input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  sdg_pkg::in_item_t                in_data,
  // result output
  output logic                             out_valid,
  input  logic                             out_stall,
  output sdg_pkg::out_item_t               out_data,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [sdg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sdg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  sdg_pkg::cfg_t      cfg;
  sdg_pkg::in_item_t  item;
  sdg_pkg::out_item_t res;
  logic               item_valid;
  logic               advance;
  logic               fire;

  logic               out_valid_r, out_valid_nxt;
  sdg_pkg::out_item_t out_data_r;

  // output register can take a new result when empty or being drained
  assign advance = !out_valid_r || !out_stall;
  // the registered frame moves into the output register, updating state
  assign fire    = item_valid && advance;

  sdg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sdg_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  sdg_eval u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .cfg   (cfg),
    .res   (res)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/core/sdg_cfg_regs.sv]
module sdg_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sdg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sdg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output sdg_pkg::cfg_t                    cfg
);

  sdg_pkg::cfg_t cfg_r;
  sdg_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        sdg_pkg::CFG_SWIPE_THR:   cfg_nxt.swipe_dist      = cfg_wdata;
        sdg_pkg::CFG_STILL_THR:   cfg_nxt.still_threshold = cfg_wdata;
        sdg_pkg::CFG_CONFIRM_CNT: cfg_nxt.confirm_count   = cfg_wdata[3:0];
        sdg_pkg::CFG_SWIPE_CD:    cfg_nxt.swipe_cooldown  = cfg_wdata[7:0];
        sdg_pkg::CFG_PAUSE_CD:    cfg_nxt.pause_cooldown  = cfg_wdata[7:0];
        sdg_pkg::CFG_SKIP_RATE:   cfg_nxt.skip_rate       = cfg_wdata[3:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.swipe_dist      <= sdg_pkg::RST_SWIPE_THR;
      cfg_r.still_threshold <= sdg_pkg::RST_STILL_THR;
      cfg_r.confirm_count   <= sdg_pkg::RST_CONFIRM_CNT;
      cfg_r.swipe_cooldown  <= sdg_pkg::RST_SWIPE_CD;
      cfg_r.pause_cooldown  <= sdg_pkg::RST_PAUSE_CD;
      cfg_r.skip_rate       <= sdg_pkg::RST_SKIP_RATE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/sdg_in_reg.sv]
module sdg_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sdg_pkg::in_item_t   in_data,
  input  logic                advance,
  output logic                item_valid,
  output sdg_pkg::in_item_t   item
);

  logic              valid_r;
  logic              valid_nxt;
  logic              load;
  sdg_pkg::in_item_t data_r;

  // full and the next stage cannot take it
  assign in_stall = valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data;
    end
  end

  assign item_valid = valid_r;
  assign item       = data_r;

endmodule

[rtl/core/sdg_eval.sv]
module sdg_eval (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  sdg_pkg::in_item_t   item,
  input  sdg_pkg::cfg_t       cfg,
  output sdg_pkg::out_item_t  res
);

  logic [3:0]      skip_cnt_r, skip_cnt_nxt;
  logic [7:0]      cooldown_r, cooldown_nxt;
  sdg_pkg::coord_t prev_x_r, prev_x_nxt;
  sdg_pkg::coord_t anchor_x_r, anchor_x_nxt;
  sdg_pkg::coord_t anchor_y_r, anchor_y_nxt;
  logic [3:0]      still_cnt_r, still_cnt_nxt;
  logic            paused_r, paused_nxt;

  logic [4:0]      skip_inc;
  logic [3:0]      still_inc;
  logic [7:0]      cd_val;
  sdg_pkg::coord_t dx;
  sdg_pkg::coord_t dy;
  sdg_pkg::det_t   det;
  sdg_pkg::event_t ev;
  logic            analysed;
  logic            swiped;

  assign dx = (item.hand_x > anchor_x_r) ? item.hand_x - anchor_x_r
                                         : anchor_x_r - item.hand_x;
  assign dy = (item.hand_y > anchor_y_r) ? item.hand_y - anchor_y_r
                                         : anchor_y_r - item.hand_y;
  assign skip_inc  = {1'b0, skip_cnt_r} + 5'd1;
  assign still_inc = (still_cnt_r < sdg_pkg::STILL_MAX) ? still_cnt_r + 4'd1 : still_cnt_r;

  always_comb begin
    skip_cnt_nxt  = skip_cnt_r;
    prev_x_nxt    = prev_x_r;
    anchor_x_nxt  = anchor_x_r;
    anchor_y_nxt  = anchor_y_r;
    still_cnt_nxt = still_cnt_r;
    paused_nxt    = paused_r;
    cd_val        = cooldown_r;
    det           = sdg_pkg::DET_NONE;
    ev            = sdg_pkg::EV_NONE;
    analysed      = 1'b0;
    swiped        = 1'b0;

    if (skip_inc > {1'b0, cfg.skip_rate}) begin
      skip_cnt_nxt = '0;
      analysed     = 1'b1;

      if (item.hand_present) begin
        if (cooldown_r == '0) begin
          // swipe check against the last analysed position
          if (prev_x_r != '0) begin
            if (item.hand_x > prev_x_r &&
                (item.hand_x - prev_x_r) > cfg.swipe_dist) begin
              det    = sdg_pkg::DET_FWD;
              swiped = 1'b1;
            end else if (prev_x_r > item.hand_x &&
                         (prev_x_r - item.hand_x) > cfg.swipe_dist) begin
              det    = sdg_pkg::DET_BACK;
              swiped = 1'b1;
            end
          end
          if (swiped) begin
            prev_x_nxt   = '0;
            anchor_x_nxt = '0;
          end else begin
            prev_x_nxt = item.hand_x;
            // stillness box around the anchor
            if (anchor_x_r == '0 || dx > cfg.still_threshold ||
                dy > cfg.still_threshold) begin
              anchor_x_nxt = item.hand_x;
              anchor_y_nxt = item.hand_y;
            end else begin
              det = sdg_pkg::DET_STILL;
            end
          end
        end
      end else begin
        prev_x_nxt    = '0;
        still_cnt_nxt = '0;
        anchor_x_nxt  = '0;
      end

      case (det)
        sdg_pkg::DET_FWD: begin
          still_cnt_nxt = '0;
          cd_val        = cfg.swipe_cooldown;
          ev            = sdg_pkg::EV_FWD;
        end
        sdg_pkg::DET_BACK: begin
          still_cnt_nxt = '0;
          cd_val        = cfg.swipe_cooldown;
          ev            = sdg_pkg::EV_BACK;
        end
        sdg_pkg::DET_STILL: begin
          if (still_inc >= cfg.confirm_count) begin
            paused_nxt    = !paused_r;
            cd_val        = cfg.pause_cooldown;
            still_cnt_nxt = '0;
            prev_x_nxt    = '0;
            anchor_x_nxt  = '0;
            ev            = sdg_pkg::EV_PAUSE;
          end else begin
            still_cnt_nxt = still_inc;
          end
        end
        default: begin
          still_cnt_nxt = '0;
        end
      endcase
    end else begin
      skip_cnt_nxt = skip_inc[3:0];
    end

    // cooldown ticks on every frame, including the one that loaded it
    cooldown_nxt = (cd_val != '0) ? cd_val - 8'd1 : cd_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_cnt_r  <= '0;
      cooldown_r  <= '0;
      prev_x_r    <= '0;
      anchor_x_r  <= '0;
      anchor_y_r  <= '0;
      still_cnt_r <= '0;
      paused_r    <= 1'b0;
    end else if (fire) begin
      skip_cnt_r  <= skip_cnt_nxt;
      cooldown_r  <= cooldown_nxt;
      prev_x_r    <= prev_x_nxt;
      anchor_x_r  <= anchor_x_nxt;
      anchor_y_r  <= anchor_y_nxt;
      still_cnt_r <= still_cnt_nxt;
      paused_r    <= paused_nxt;
    end
  end

  assign res.event_res = ev;
  assign res.paused    = paused_nxt;
  assign res.analysed  = analysed;

endmodule

[rtl/core/sdg_checker.sv]
module sdg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input sdg_pkg::out_item_t out_data
);

  logic seen_r;
  logic last_paused_r;

  // paused flag of the last delivered transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r        <= 1'b0;
      last_paused_r <= 1'b0;
    end else if (out_valid && !out_stall) begin
      seen_r        <= 1'b1;
      last_paused_r <= out_data.paused;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  // events come only from analysed frames
  a_event_analysed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.analysed |-> out_data.event_res == sdg_pkg::EV_NONE)
    else $error("event on a skipped frame");

  // paused flag flips exactly on a pause event
  a_pause_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_r |->
      ((out_data.paused != last_paused_r) ==
       (out_data.event_res == sdg_pkg::EV_PAUSE)))
    else $error("paused flag out of step with pause events");

  // input backpressure only when the output side is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("input stalled while output side is free");

endmodule

bind swipe_and_dwell_gesture_detector sdg_checker u_sdg_checker (.*);

[tb/sv/sdg_result_checker.sv]
module sdg_result_checker
  import sdg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    frames_in_flight
);

  // shadow of the register file and of the gesture state
  cfg_t       regs;
  logic [3:0] skip_cnt;
  logic [7:0] cooldown;
  coord_t     prev_x;
  coord_t     anchor_x;
  coord_t     anchor_y;
  logic [3:0] still_cnt;
  logic       paused_q;

  out_item_t  frame_results[$];

  // position analysis on a frame that has a hand and no cooldown
  function automatic det_t classify_position(input coord_t x, input coord_t y);
    coord_t px;
    coord_t ddx;
    coord_t ddy;
    if (prev_x != '0) begin
      px     = prev_x;
      prev_x = '0;
      if (x > px && (x - px) > regs.swipe_dist) begin
        anchor_x = '0;
        return DET_FWD;
      end
      if (px > x && (px - x) > regs.swipe_dist) begin
        anchor_x = '0;
        return DET_BACK;
      end
    end
    prev_x = x;
    if (anchor_x == '0) begin
      anchor_x = x;
      anchor_y = y;
      return DET_NONE;
    end
    ddx = (x > anchor_x) ? x - anchor_x : anchor_x - x;
    ddy = (y > anchor_y) ? y - anchor_y : anchor_y - y;
    if (ddx > regs.still_threshold || ddy > regs.still_threshold) begin
      anchor_x = x;
      anchor_y = y;
      return DET_NONE;
    end
    return DET_STILL;
  endfunction

  // one frame through the gesture state, giving its result
  function automatic out_item_t next_frame_result(input in_item_t fr);
    det_t       det;
    event_t     ev;
    logic [4:0] nxt;
    out_item_t  res;
    det = DET_NONE;
    ev  = EV_NONE;
    nxt = {1'b0, skip_cnt} + 5'd1;
    res.analysed = 1'b0;
    if (nxt > {1'b0, regs.skip_rate}) begin
      skip_cnt     = '0;
      res.analysed = 1'b1;
      if (fr.hand_present) begin
        if (cooldown == '0)
          det = classify_position(fr.hand_x, fr.hand_y);
      end else begin
        prev_x    = '0;
        still_cnt = '0;
        anchor_x  = '0;
      end
      if (cooldown == '0 && det != DET_NONE) begin
        if (det == DET_FWD || det == DET_BACK) begin
          still_cnt = '0;
          cooldown  = regs.swipe_cooldown;
          ev        = (det == DET_FWD) ? EV_FWD : EV_BACK;
        end else begin
          if (still_cnt < STILL_MAX)
            still_cnt = still_cnt + 4'd1;
          if (still_cnt >= regs.confirm_count) begin
            paused_q  = ~paused_q;
            cooldown  = regs.pause_cooldown;
            still_cnt = '0;
            prev_x    = '0;
            anchor_x  = '0;
            ev        = EV_PAUSE;
          end
        end
      end
      if (det == DET_NONE)
        still_cnt = '0;
    end else begin
      skip_cnt = nxt[3:0];
    end
    if (cooldown != '0)
      cooldown = cooldown - 8'd1;
    res.event_res = ev;
    res.paused    = paused_q;
    return res;
  endfunction

  function automatic void report_field(input string field, input int unsigned want,
                                       input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count = mismatch_count + 1;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      regs.swipe_dist      = RST_SWIPE_THR;
      regs.still_threshold = RST_STILL_THR;
      regs.confirm_count   = RST_CONFIRM_CNT;
      regs.swipe_cooldown  = RST_SWIPE_CD;
      regs.pause_cooldown  = RST_PAUSE_CD;
      regs.skip_rate       = RST_SKIP_RATE;
      skip_cnt  = '0;
      cooldown  = '0;
      prev_x    = '0;
      anchor_x  = '0;
      anchor_y  = '0;
      still_cnt = '0;
      paused_q  = 1'b0;
      frame_results.delete();
      mismatch_count   = 0;
      frames_in_flight = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SWIPE_THR:   regs.swipe_dist      = cfg_wdata;
          CFG_STILL_THR:   regs.still_threshold = cfg_wdata;
          CFG_CONFIRM_CNT: regs.confirm_count   = cfg_wdata[3:0];
          CFG_SWIPE_CD:    regs.swipe_cooldown  = cfg_wdata[7:0];
          CFG_PAUSE_CD:    regs.pause_cooldown  = cfg_wdata[7:0];
          CFG_SKIP_RATE:   regs.skip_rate       = cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (frame_results.size() == 0) begin
          $display("%0t: unexpected result transaction, actual %0d/%0d/%0d", $time,
                   out_data.event_res, out_data.paused, out_data.analysed);
          mismatch_count = mismatch_count + 1;
        end else begin
          want = frame_results.pop_front();
          report_field("event_res", 32'(want.event_res), 32'(out_data.event_res));
          report_field("paused", 32'(want.paused), 32'(out_data.paused));
          report_field("analysed", 32'(want.analysed), 32'(out_data.analysed));
        end
      end
      if (in_valid && !in_stall)
        frame_results.push_back(next_frame_result(in_data));
      frames_in_flight = frame_results.size();
    end
  end

endmodule

[tb/sv/tb_swipe_and_dwell_gesture_detector.sv]
module tb_swipe_and_dwell_gesture_detector;
  import sdg_pkg::*;

  // cycles in a row with no transaction on either channel before giving up
  localparam int WATCHDOG_LIMIT = 2000;
  // register index outside the map, the block must ignore it
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int mismatch_count;
  int frames_in_flight;
  int idle_cycles;

  // no_idle turns off both the frame gaps and the result stalls
  bit no_idle;
  // current thresholds, used to shape dwell jitter and swipe steps
  int still_cur;
  int swipe_cur;

  // hand-picked frames, run with skip 0, confirm 2, swipe cooldown 0, pause cooldown 3
  in_item_t dir_frames [22] = '{
    {1'b0, 9'd0,   9'd0},    // no hand
    {1'b1, 9'd0,   9'd0},    // hand at x zero, not remembered
    {1'b1, 9'd0,   9'd5},
    {1'b1, 9'd100, 9'd100},  // anchor
    {1'b1, 9'd110, 9'd90},   // still once
    {1'b1, 9'd115, 9'd100},  // still twice, pause toggles
    {1'b1, 9'd200, 9'd100},  // cooldown running
    {1'b1, 9'd200, 9'd100},
    {1'b1, 9'd200, 9'd100},  // cooldown over, fresh anchor
    {1'b1, 9'd251, 9'd100},  // move of 51, swipe forward
    {1'b1, 9'd251, 9'd100},
    {1'b1, 9'd201, 9'd100},  // move of exactly the threshold, no swipe
    {1'b1, 9'd150, 9'd100},  // swipe back
    {1'b1, 9'd511, 9'd511},  // all ones
    {1'b1, 9'd1,   9'd1},    // big jump back
    {1'b1, 9'd279, 9'd279},
    {1'b1, 9'd279, 9'd264},  // y drift at the still limit
    {1'b1, 9'd264, 9'd279},  // x drift at the still limit, toggles again
    {1'b0, 9'd511, 9'd511},  // no hand while cooling down
    {1'b1, 9'd0,   9'd511},
    {1'b1, 9'd0,   9'd0},
    {1'b1, 9'd300, 9'd0}     // coordinate past the region of interest
  };

  swipe_and_dwell_gesture_detector uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // watches both channels and the register writes, predicts and compares
  sdg_result_checker frame_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatch_count   (mismatch_count),
    .frames_in_flight (frames_in_flight)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side back-pressure, changed at the falling edge only
  initial out_stall = 1'b0;
  always @(negedge clk) begin
    out_stall = rst_n && !no_idle && ($urandom_range(0, 99) < 23);
  end

  // watchdog: ends the run if neither channel moves for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // one register write, called and returning at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic write_all_regs(input cfg_t c);
    write_reg(CFG_SWIPE_THR, c.swipe_dist);
    write_reg(CFG_STILL_THR, c.still_threshold);
    write_reg(CFG_CONFIRM_CNT, 9'(c.confirm_count));
    write_reg(CFG_SWIPE_CD, 9'(c.swipe_cooldown));
    write_reg(CFG_PAUSE_CD, 9'(c.pause_cooldown));
    write_reg(CFG_SKIP_RATE, 9'(c.skip_rate));
    still_cur = int'(c.still_threshold);
    swipe_cur = int'(c.swipe_dist);
  endtask

  // offer one frame, with random gaps ahead of it, and hold it until accepted;
  // valid stays high after acceptance so back-to-back frames need no toggle
  task automatic send_frame(input in_item_t f);
    while (!no_idle && $urandom_range(0, 99) < 23) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = f;
    do
      @(posedge clk);
    while (in_stall);
    @(negedge clk);
  endtask

  // block idle: every predicted result has come back
  task automatic wait_drained();
    in_valid = 1'b0;
    while (frames_in_flight != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // random gesture traffic: mostly dwells and swipes with random content,
  // some hand-absent runs and some raw noise over the whole field range
  task automatic run_random(input int count);
    int       left;
    int       mode;
    int       bx;
    int       by;
    int       jit;
    int       stride;
    bit       rightward;
    in_item_t f;
    left = 0;
    mode = 0;
    bx   = 1;
    by   = 1;
    jit  = 0;
    stride = 0;
    rightward = 1'b0;
    for (int n = 0; n < count; n++) begin
      if (left == 0) begin
        left      = $urandom_range(2, 24);
        mode      = $urandom_range(0, 99);
        bx        = $urandom_range(1, 279);
        by        = $urandom_range(1, 279);
        jit       = $urandom_range(0, still_cur + 2);
        stride    = $urandom_range(0, 2 * swipe_cur + 20);
        rightward = 1'($urandom_range(0, 1));
      end
      left = left - 1;
      if (mode < 45) begin
        // dwell: jitter around a point, mostly inside the still box
        f.hand_present = 1'b1;
        f.hand_x = coord_t'((bx + $urandom_range(0, 2 * jit) - jit) & 511);
        f.hand_y = coord_t'((by + $urandom_range(0, 2 * jit) - jit) & 511);
      end else if (mode < 70) begin
        // swipe: steady drift in one direction, the coordinate wraps
        bx = rightward ? (bx + stride) & 511 : (bx - stride) & 511;
        f.hand_present = 1'b1;
        f.hand_x = coord_t'(bx);
        f.hand_y = coord_t'((by + $urandom_range(0, 8)) & 511);
      end else if (mode < 80) begin
        // hand gone, coordinates are junk
        f.hand_present = 1'b0;
        f.hand_x = coord_t'($urandom_range(0, 511));
        f.hand_y = coord_t'($urandom_range(0, 511));
      end else begin
        f.hand_present = 1'($urandom_range(0, 1));
        f.hand_x = coord_t'($urandom_range(0, 511));
        f.hand_y = coord_t'($urandom_range(0, 511));
      end
      send_frame(f);
    end
  endtask

  initial begin
    cfg_t c;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    no_idle   = 1'b0;
    still_cur = int'(RST_STILL_THR);
    swipe_cur = int'(RST_SWIPE_THR);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values of the registers, nothing written yet
    run_random(150);
    wait_drained();

    // directed frames
    c.swipe_dist      = 9'd50;
    c.still_threshold = 9'd15;
    c.confirm_count   = 4'd2;
    c.swipe_cooldown  = 8'd0;
    c.pause_cooldown  = 8'd3;
    c.skip_rate       = 4'd0;
    write_all_regs(c);
    foreach (dir_frames[i])
      send_frame(dir_frames[i]);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          // everything at its low end, except the confirm count of one
          c.swipe_dist      = 9'd0;
          c.still_threshold = 9'd0;
          c.confirm_count   = 4'd1;
          c.swipe_cooldown  = 8'd0;
          c.pause_cooldown  = 8'd0;
          c.skip_rate       = 4'd0;
          write_reg(CFG_UNMAPPED, 9'($urandom_range(0, 511)));
        end
        1: begin
          // everything at its high end
          c.swipe_dist      = 9'd511;
          c.still_threshold = 9'd511;
          c.confirm_count   = 4'd15;
          c.swipe_cooldown  = 8'd255;
          c.pause_cooldown  = 8'd255;
          c.skip_rate       = 4'd15;
        end
        2: begin
          // confirm count of zero: first still frame toggles pause
          c.swipe_dist      = 9'd60;
          c.still_threshold = 9'd20;
          c.confirm_count   = 4'd0;
          c.swipe_cooldown  = 8'd5;
          c.pause_cooldown  = 8'd5;
          c.skip_rate       = 4'd0;
        end
        default: begin
          c.swipe_dist      = coord_t'($urandom_range(0, 279));
          c.still_threshold = coord_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 279)
                                                                   : $urandom_range(0, 40));
          c.confirm_count   = 4'($urandom_range(1, 15));
          c.swipe_cooldown  = 8'($urandom_range(0, 40));
          c.pause_cooldown  = 8'($urandom_range(0, 60));
          c.skip_rate       = 4'($urandom_range(0, 4));
        end
      endcase
      write_all_regs(c);
      // one phase runs flat out on both sides
      no_idle = (ph == 4);
      run_random(215);
      wait_drained();
    end
    no_idle = 1'b0;

    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && frames_in_flight == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[swipe_and_dwell_gesture_detector.f]
rtl/core/sdg_pkg.sv
rtl/core/sdg_cfg_regs.sv
rtl/core/sdg_in_reg.sv
rtl/core/sdg_eval.sv
rtl/core/swipe_and_dwell_gesture_detector.sv
rtl/core/sdg_checker.sv
tb/sv/sdg_result_checker.sv
tb/sv/tb_swipe_and_dwell_gesture_detector.sv
